### src/mlfq_pkg.sv
// shared types, codes and reset values for the multilevel feedback queue scheduler
// used by mlfq_seq and mlfq_task_scheduler_unit; no dependencies
package mlfq_pkg;

    localparam int DEF_TASK_SLOTS  = 32;
    localparam int DEF_LEVELS      = 16;
    localparam int DEF_LEVEL_DEPTH = 16;

    localparam int SLOT_W     = 5;
    localparam int FUNC_W     = 3;
    localparam int ERR_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [FUNC_W-1:0] FN_TICK   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SETRUN = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_YIELD  = 3'd4;

    localparam logic [ERR_W-1:0] ERR_OK          = 3'd0;
    localparam logic [ERR_W-1:0] ERR_PRESENT     = 3'd1;
    localparam logic [ERR_W-1:0] ERR_NOT_PRESENT = 3'd2;
    localparam logic [ERR_W-1:0] ERR_LEVEL_FULL  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_NO_RUN      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd3;

    localparam logic [4:0]  RST_LEVELS  = 5'd16;
    localparam logic [9:0]  RST_QUANTUM = 10'd5;
    localparam logic [15:0] RST_BOOST   = 16'd1000;
    localparam logic [3:0]  RST_STEP    = 4'd4;

    typedef struct packed {
        logic [4:0]  level_count;
        logic [9:0]  quantum_unit;
        logic [15:0] boost_period;
        logic [3:0]  tick_step;
    } t_cfg;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] slot_id;
        logic              runnable_flag;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] running_slot;
        logic              has_task;
        logic              switched;
        logic              boosted;
        logic [ERR_W-1:0]  error_code;
    } t_res;

    typedef enum logic [5:0] {
        ST_IDLE, ST_DISP, ST_TICK1, ST_BOOST0, ST_BST1, ST_BST2, ST_BST3,
        ST_MV0, ST_MV1, ST_MV2, ST_MV3, ST_LF0, ST_LF1, ST_DR0, ST_DR1,
        ST_OF0, ST_OF1, ST_SCH0, ST_SCH1, ST_SCH2, ST_SEL0, ST_RRI, ST_RR0,
        ST_RR1, ST_LV0, ST_SC0, ST_SC1, ST_PICK0, ST_PICK1, ST_NOPICK,
        ST_RM1, ST_RM2, ST_RM3, ST_RM4, ST_RM5, ST_RO0, ST_RO1, ST_DONE
    } t_state;

endpackage

### src/mlfq_seq.sv
// scheduler sequencer: queue memories, task state and the event state machine
// depends on mlfq_pkg
module mlfq_seq #(
    parameter int TASK_SLOTS  = mlfq_pkg::DEF_TASK_SLOTS,
    parameter int LEVELS      = mlfq_pkg::DEF_LEVELS,
    parameter int LEVEL_DEPTH = mlfq_pkg::DEF_LEVEL_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mlfq_pkg::t_cfg i_cfg,
    input  logic           i_start,
    input  mlfq_pkg::t_req i_req,
    input  logic           i_res_free,
    output logic           o_idle,
    output logic           o_done,
    output mlfq_pkg::t_res o_res
);
    import mlfq_pkg::*;

    localparam int SIW  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int LW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int LIW  = $clog2(LEVEL_DEPTH);
    localparam int FW   = $clog2(LEVEL_DEPTH + 1);
    localparam int TOW  = $clog2(TASK_SLOTS + 1);
    localparam int MAXN = (TASK_SLOTS > LEVEL_DEPTH) ? TASK_SLOTS : LEVEL_DEPTH;
    localparam int CW   = $clog2(2 * MAXN + 1);
    localparam int MAW  = LW + LIW;

    t_state r_state, n_state;
    t_state r_ret_find, n_ret_find, r_ret_drop, n_ret_drop;
    t_state r_ret_move, n_ret_move, r_ret_of, n_ret_of;
    logic [FUNC_W-1:0] r_func, n_func;
    logic [SLOT_W-1:0] r_sid, n_sid, r_cur, n_cur, r_was_slot, n_was_slot;
    logic [SLOT_W-1:0] r_s, n_s, r_pick, n_pick;
    logic r_flag, n_flag, r_boost, n_boost, r_was_v, n_was_v, r_cur_v, n_cur_v;
    logic r_found, n_found, r_had, n_had, r_old_found, n_old_found;
    logic r_scan_a, n_scan_a;
    logic [ERR_W-1:0] r_err, n_err;
    logic [31:0] r_time, n_time, r_sb, n_sb, r_se, n_se, r_lb, n_lb;
    logic [31:0] r_used, n_used;
    logic [TASK_SLOTS-1:0] r_valid, n_valid, r_run, n_run;
    logic [FW-1:0] r_fill [LEVELS];
    logic [FW-1:0] n_fill [LEVELS];
    logic [TOW-1:0] r_ofill, n_ofill, r_bi, n_bi;
    logic [LW-1:0] r_lv, n_lv, r_flv, n_flv, r_to, n_to, r_old_lv, n_old_lv;
    logic [CW-1:0] r_idx, n_idx, r_pos, n_pos, r_old_idx, n_old_idx, r_start, n_start;

    logic [SLOT_W-1:0] r_lm_mem [2**MAW];
    logic [SLOT_W-1:0] r_lm_q, w_lm_wd;
    logic [MAW-1:0]    w_lm_wa, w_lm_ra;
    logic              w_lm_we;
    logic [LW-1:0]     r_lv_mem [TASK_SLOTS];
    logic [LW-1:0]     r_lv_q, w_lv_wd;
    logic [SIW-1:0]    w_lv_wa, w_lv_ra;
    logic              w_lv_we;
    logic [31:0]       r_ut_mem [TASK_SLOTS];
    logic [31:0]       r_ut_q, w_ut_wd;
    logic [SIW-1:0]    w_ut_wa, w_ut_ra;
    logic              w_ut_we;
    logic [SLOT_W-1:0] r_or_mem [TASK_SLOTS];
    logic [SLOT_W-1:0] r_or_q, w_or_wd;
    logic [SIW-1:0]    w_or_wa, w_or_ra;
    logic              w_or_we;

    logic [4:0]  w_nl;
    logic        w_oor, w_present, w_special;
    logic [31:0] w_el, w_used;
    logic [32:0] w_sat;
    logic [LW-1:0] w_q_lv;
    logic [14:0] w_quant;
    logic [CW-1:0] w_idx1, w_rr_sum, w_rr_idx;
    t_state w_sch_ret;

    always_ff @(posedge i_clk) begin
        if (w_lm_we) r_lm_mem[w_lm_wa] <= w_lm_wd;
        r_lm_q <= r_lm_mem[w_lm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_lv_we) r_lv_mem[w_lv_wa] <= w_lv_wd;
        r_lv_q <= r_lv_mem[w_lv_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_ut_we) r_ut_mem[w_ut_wa] <= w_ut_wd;
        r_ut_q <= r_ut_mem[w_ut_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_or_we) r_or_mem[w_or_wa] <= w_or_wd;
        r_or_q <= r_or_mem[w_or_ra];
    end

    assign w_nl = (i_cfg.level_count == 5'd0) ? 5'd1 :
                  (32'(i_cfg.level_count) > 32'(LEVELS)) ? 5'(LEVELS) : i_cfg.level_count;
    assign w_oor     = 32'(r_sid) >= 32'(TASK_SLOTS);
    assign w_present = !w_oor && r_valid[SIW'(r_sid)];
    assign w_el      = r_time - r_sb;
    assign w_sat     = {1'b0, r_ut_q} + {1'b0, w_el};
    assign w_used    = w_sat[32] ? '1 : w_sat[31:0];
    // one shared slice multiplier
    assign w_q_lv    = (r_state == ST_PICK1) ? r_lv_q : r_old_lv;
    assign w_quant   = 15'(i_cfg.quantum_unit) * (15'(w_q_lv) + 15'd1);
    assign w_idx1    = r_idx + CW'(1);
    assign w_rr_sum  = r_start + r_idx;
    assign w_rr_idx  = (w_rr_sum >= CW'(r_ofill)) ? w_rr_sum - CW'(r_ofill) : w_rr_sum;
    assign w_special = r_had && (r_lv == r_old_lv) && r_old_found &&
                       ((r_old_idx + CW'(1)) < CW'(r_fill[r_lv]));
    assign w_sch_ret = (r_func == FN_TICK) ? ST_BOOST0 : ST_DONE;

    assign o_idle = (r_state == ST_IDLE);
    assign o_res.running_slot = r_cur_v ? r_cur : '0;
    assign o_res.has_task     = r_cur_v;
    assign o_res.switched     = (r_was_v != r_cur_v) || (r_cur_v && (r_was_slot != r_cur));
    assign o_res.boosted      = r_boost;
    assign o_res.error_code   = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cur   <= '0;
            r_cur_v <= 1'b0;
            r_time  <= '0;
            r_sb    <= '0;
            r_se    <= '0;
            r_lb    <= '0;
            r_valid <= '0;
            r_run   <= '0;
            r_ofill <= '0;
            for (int i = 0; i < LEVELS; i++) r_fill[i] <= '0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_cur_v <= n_cur_v;
            r_time  <= n_time;
            r_sb    <= n_sb;
            r_se    <= n_se;
            r_lb    <= n_lb;
            r_valid <= n_valid;
            r_run   <= n_run;
            r_ofill <= n_ofill;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret_find  <= n_ret_find;
        r_ret_drop  <= n_ret_drop;
        r_ret_move  <= n_ret_move;
        r_ret_of    <= n_ret_of;
        r_func      <= n_func;
        r_sid       <= n_sid;
        r_flag      <= n_flag;
        r_err       <= n_err;
        r_boost     <= n_boost;
        r_was_v     <= n_was_v;
        r_was_slot  <= n_was_slot;
        r_s         <= n_s;
        r_pick      <= n_pick;
        r_found     <= n_found;
        r_had       <= n_had;
        r_old_found <= n_old_found;
        r_scan_a    <= n_scan_a;
        r_used      <= n_used;
        r_bi        <= n_bi;
        r_lv        <= n_lv;
        r_flv       <= n_flv;
        r_to        <= n_to;
        r_old_lv    <= n_old_lv;
        r_idx       <= n_idx;
        r_pos       <= n_pos;
        r_old_idx   <= n_old_idx;
        r_start     <= n_start;
    end

    always_comb begin
        n_state = r_state;     n_ret_find = r_ret_find; n_ret_drop = r_ret_drop;
        n_ret_move = r_ret_move; n_ret_of = r_ret_of;   n_func = r_func;
        n_sid = r_sid;         n_flag = r_flag;         n_err = r_err;
        n_boost = r_boost;     n_was_v = r_was_v;       n_was_slot = r_was_slot;
        n_cur = r_cur;         n_cur_v = r_cur_v;       n_s = r_s;
        n_pick = r_pick;       n_found = r_found;       n_had = r_had;
        n_old_found = r_old_found; n_scan_a = r_scan_a; n_used = r_used;
        n_time = r_time;       n_sb = r_sb;             n_se = r_se;
        n_lb = r_lb;           n_valid = r_valid;       n_run = r_run;
        n_fill = r_fill;       n_ofill = r_ofill;       n_bi = r_bi;
        n_lv = r_lv;           n_flv = r_flv;           n_to = r_to;
        n_old_lv = r_old_lv;   n_idx = r_idx;           n_pos = r_pos;
        n_old_idx = r_old_idx; n_start = r_start;
        w_lm_we = 1'b0; w_lm_wa = '0; w_lm_wd = '0; w_lm_ra = '0;
        w_lv_we = 1'b0; w_lv_wa = '0; w_lv_wd = '0; w_lv_ra = '0;
        w_ut_we = 1'b0; w_ut_wa = '0; w_ut_wd = '0; w_ut_ra = '0;
        w_or_we = 1'b0; w_or_wa = '0; w_or_wd = '0; w_or_ra = '0;
        o_done  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_func     = i_req.func;
                    n_sid      = i_req.slot_id;
                    n_flag     = i_req.runnable_flag;
                    n_err      = ERR_OK;
                    n_boost    = 1'b0;
                    n_was_v    = r_cur_v;
                    n_was_slot = r_cur;
                    n_state    = ST_DISP;
                end
            end
            ST_DISP: begin
                n_state = ST_DONE;
                case (r_func)
                    FN_TICK: begin
                        n_time  = r_time + 32'(i_cfg.tick_step);
                        n_state = ST_TICK1;
                    end
                    FN_ADD: begin
                        if (w_oor) begin
                            n_err = ERR_NOT_PRESENT;
                        end else if (w_present) begin
                            n_err = ERR_PRESENT;
                        end else if (r_fill[0] >= FW'(LEVEL_DEPTH) ||
                                     r_ofill >= TOW'(TASK_SLOTS)) begin
                            n_err = ERR_LEVEL_FULL;
                        end else begin
                            n_valid[SIW'(r_sid)] = 1'b1;
                            n_run[SIW'(r_sid)]   = 1'b1;
                            w_lv_we = 1'b1; w_lv_wa = SIW'(r_sid); w_lv_wd = '0;
                            w_ut_we = 1'b1; w_ut_wa = SIW'(r_sid); w_ut_wd = '0;
                            w_or_we = 1'b1; w_or_wa = SIW'(r_ofill); w_or_wd = r_sid;
                            n_ofill = r_ofill + TOW'(1);
                            w_lm_we = 1'b1;
                            w_lm_wa = {LW'(0), r_fill[0][LIW-1:0]};
                            w_lm_wd = r_sid;
                            n_fill[0] = r_fill[0] + FW'(1);
                        end
                    end
                    FN_SETRUN: begin
                        if (!w_present) begin
                            n_err = ERR_NOT_PRESENT;
                        end else begin
                            n_run[SIW'(r_sid)] = r_flag;
                            if (!r_flag && r_cur_v && r_cur == r_sid) n_state = ST_SCH0;
                        end
                    end
                    FN_REMOVE: begin
                        if (!w_present) begin
                            n_err = ERR_NOT_PRESENT;
                        end else begin
                            w_lv_ra = SIW'(r_sid);
                            n_s     = r_sid;
                            n_state = ST_RM1;
                        end
                    end
                    FN_YIELD: n_state = ST_SCH0;
                    default: n_state = ST_DONE;
                endcase
            end
            ST_TICK1: begin
                if (!r_cur_v || (r_time - r_sb) >= (r_se - r_sb)) n_state = ST_SCH0;
                else n_state = ST_BOOST0;
            end
            ST_BOOST0: begin
                if (w_nl > 5'd1 && (r_time - r_lb) >= 32'(i_cfg.boost_period)) begin
                    n_lb    = r_time;
                    n_boost = 1'b1;
                    n_bi    = '0;
                    n_state = ST_BST1;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_BST1: begin
                if (r_bi < r_ofill) begin
                    w_or_ra = SIW'(r_bi);
                    n_state = ST_BST2;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_BST2: begin
                n_s        = r_or_q;
                n_to       = '0;
                n_ret_move = ST_BST3;
                n_state    = ST_MV0;
            end
            ST_BST3: begin
                n_bi    = r_bi + TOW'(1);
                n_state = ST_BST1;
            end
            ST_MV0: begin
                w_lv_ra = SIW'(r_s);
                n_state = ST_MV1;
            end
            ST_MV1: begin
                n_flv      = r_lv_q;
                n_idx      = '0;
                n_ret_find = ST_MV2;
                n_state    = ST_LF0;
            end
            ST_MV2: begin
                if (!r_found) begin
                    n_state = r_ret_move;
                end else if (r_to != r_flv && r_fill[r_to] >= FW'(LEVEL_DEPTH)) begin
                    n_state = r_ret_move;
                end else begin
                    n_idx      = r_pos;
                    n_ret_drop = ST_MV3;
                    n_state    = ST_DR0;
                end
            end
            ST_MV3: begin
                w_lm_we = 1'b1;
                w_lm_wa = {r_to, r_fill[r_to][LIW-1:0]};
                w_lm_wd = r_s;
                n_fill[r_to] = r_fill[r_to] + FW'(1);
                w_lv_we = 1'b1; w_lv_wa = SIW'(r_s); w_lv_wd = r_to;
                w_ut_we = 1'b1; w_ut_wa = SIW'(r_s); w_ut_wd = '0;
                n_state = r_ret_move;
            end
            ST_LF0: begin
                if (r_idx < CW'(r_fill[r_flv])) begin
                    w_lm_ra = {r_flv, r_idx[LIW-1:0]};
                    n_state = ST_LF1;
                end else begin
                    n_found = 1'b0;
                    n_state = r_ret_find;
                end
            end
            ST_LF1: begin
                if (r_lm_q == r_s) begin
                    n_found = 1'b1;
                    n_pos   = r_idx;
                    n_state = r_ret_find;
                end else begin
                    n_idx   = w_idx1;
                    n_state = ST_LF0;
                end
            end
            ST_DR0: begin
                if (w_idx1 < CW'(r_fill[r_flv])) begin
                    w_lm_ra = {r_flv, w_idx1[LIW-1:0]};
                    n_state = ST_DR1;
                end else begin
                    n_fill[r_flv] = r_fill[r_flv] - FW'(1);
                    n_state = r_ret_drop;
                end
            end
            ST_DR1: begin
                w_lm_we = 1'b1;
                w_lm_wa = {r_flv, r_idx[LIW-1:0]};
                w_lm_wd = r_lm_q;
                n_idx   = w_idx1;
                n_state = ST_DR0;
            end
            ST_OF0: begin
                if (r_idx < CW'(r_ofill)) begin
                    w_or_ra = SIW'(r_idx);
                    n_state = ST_OF1;
                end else begin
                    n_found = 1'b0;
                    n_state = r_ret_of;
                end
            end
            ST_OF1: begin
                if (r_or_q == r_s) begin
                    n_found = 1'b1;
                    n_pos   = r_idx;
                    n_state = r_ret_of;
                end else begin
                    n_idx   = w_idx1;
                    n_state = ST_OF0;
                end
            end
            ST_SCH0: begin
                n_had = r_cur_v;
                n_s   = r_cur;
                if (r_cur_v) begin
                    w_lv_ra = SIW'(r_cur);
                    w_ut_ra = SIW'(r_cur);
                    n_state = ST_SCH1;
                end else begin
                    n_state = ST_SEL0;
                end
            end
            ST_SCH1: begin
                n_old_lv   = r_lv_q;
                n_flv      = r_lv_q;
                n_used     = w_used;
                n_idx      = '0;
                n_ret_find = ST_SCH2;
                n_state    = ST_LF0;
            end
            ST_SCH2: begin
                n_old_found = r_found;
                n_old_idx   = r_pos;
                w_ut_we = 1'b1; w_ut_wa = SIW'(r_cur); w_ut_wd = r_used;
                if (r_used >= 32'(w_quant) && (5'(r_old_lv) + 5'd1) < w_nl) begin
                    n_to       = r_old_lv + LW'(1);
                    n_ret_move = ST_SEL0;
                    n_state    = ST_MV0;
                end else begin
                    n_state = ST_SEL0;
                end
            end
            ST_SEL0: begin
                if (w_nl == 5'd1) begin
                    n_idx = '0;
                    if (r_had) begin
                        n_ret_of = ST_RRI;
                        n_state  = ST_OF0;
                    end else begin
                        n_found = 1'b0;
                        n_state = ST_RRI;
                    end
                end else begin
                    n_lv    = '0;
                    n_state = ST_LV0;
                end
            end
            ST_RRI: begin
                n_start = r_found ? r_pos + CW'(1) : '0;
                n_idx   = '0;
                n_state = ST_RR0;
            end
            ST_RR0: begin
                if (r_idx < CW'(r_ofill)) begin
                    w_or_ra = SIW'(w_rr_idx);
                    n_state = ST_RR1;
                end else begin
                    n_state = ST_NOPICK;
                end
            end
            ST_RR1: begin
                if (r_run[SIW'(r_or_q)]) begin
                    n_pick  = r_or_q;
                    n_state = ST_PICK0;
                end else begin
                    n_idx   = w_idx1;
                    n_state = ST_RR0;
                end
            end
            ST_LV0: begin
                n_scan_a = w_special;
                n_idx    = w_special ? r_old_idx + CW'(1) : '0;
                n_state  = ST_SC0;
            end
            ST_SC0: begin
                if (r_idx < CW'(r_fill[r_lv])) begin
                    w_lm_ra = {r_lv, r_idx[LIW-1:0]};
                    n_state = ST_SC1;
                end else if (r_scan_a) begin
                    n_scan_a = 1'b0;
                    n_idx    = '0;
                end else if (r_lv == LW'(LEVELS - 1)) begin
                    n_state = ST_NOPICK;
                end else begin
                    n_lv    = r_lv + LW'(1);
                    n_state = ST_LV0;
                end
            end
            ST_SC1: begin
                if (r_run[SIW'(r_lm_q)]) begin
                    n_pick  = r_lm_q;
                    n_state = ST_PICK0;
                end else begin
                    n_idx   = w_idx1;
                    n_state = ST_SC0;
                end
            end
            ST_PICK0: begin
                w_lv_ra = SIW'(r_pick);
                n_state = ST_PICK1;
            end
            ST_PICK1: begin
                n_cur   = r_pick;
                n_cur_v = 1'b1;
                n_sb    = r_time;
                n_se    = r_time + 32'(w_quant);
                n_state = w_sch_ret;
            end
            ST_NOPICK: begin
                n_cur   = '0;
                n_cur_v = 1'b0;
                n_err   = ERR_NO_RUN;
                n_state = w_sch_ret;
            end
            ST_RM1: begin
                n_flv      = r_lv_q;
                n_idx      = '0;
                n_ret_find = ST_RM2;
                n_state    = ST_LF0;
            end
            ST_RM2: begin
                if (r_found) begin
                    n_idx      = r_pos;
                    n_ret_drop = ST_RM3;
                    n_state    = ST_DR0;
                end else begin
                    n_state = ST_RM3;
                end
            end
            ST_RM3: begin
                n_idx    = '0;
                n_ret_of = ST_RM4;
                n_state  = ST_OF0;
            end
            ST_RM4: begin
                if (r_found) begin
                    n_idx   = r_pos;
                    n_state = ST_RO0;
                end else begin
                    n_state = ST_RM5;
                end
            end
            ST_RO0: begin
                if (w_idx1 < CW'(r_ofill)) begin
                    w_or_ra = SIW'(w_idx1);
                    n_state = ST_RO1;
                end else begin
                    n_ofill = r_ofill - TOW'(1);
                    n_state = ST_RM5;
                end
            end
            ST_RO1: begin
                w_or_we = 1'b1; w_or_wa = SIW'(r_idx); w_or_wd = r_or_q;
                n_idx   = w_idx1;
                n_state = ST_RO0;
            end
            ST_RM5: begin
                n_valid[SIW'(r_sid)] = 1'b0;
                n_run[SIW'(r_sid)]   = 1'b0;
                if (r_cur_v && r_cur == r_sid) begin
                    n_cur_v = 1'b0;
                    n_cur   = '0;
                    n_state = ST_SCH0;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_free) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

### src/mlfq_task_scheduler_unit.sv
// channel       | dir | payload
// s_axis        | in  | tdata: slot_id, runnable_flag; tuser: func
// m_axis        | out | tdata: running_slot, has_task, switched, boosted, error_code
// cfg write     | in  | i_cfg_index, i_cfg_data; always ready
// one event at a time: add needs no queue walk; tick, yield and remove walk the queues,
// reading one queue or task-list entry at a time plus a find and shift per move,
// so a boost's cost grows with TASK_SLOTS * LEVEL_DEPTH
// the sequencer and its queue memories, one read and one write port each, set the rate
// s_axis_tready is high only while the sequencer is idle; the result register
// lets the next event start while a result waits. reset is synchronous, active low
// top level of the scheduler; depends on mlfq_pkg and mlfq_seq
module mlfq_task_scheduler_unit #(
    parameter int TASK_SLOTS  = mlfq_pkg::DEF_TASK_SLOTS,
    parameter int LEVELS      = mlfq_pkg::DEF_LEVELS,
    parameter int LEVEL_DEPTH = mlfq_pkg::DEF_LEVEL_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // [4:0] slot_id, [5] runnable_flag
    input  logic [mlfq_pkg::FUNC_W-1:0]        s_axis_tuser,  // [2:0] func
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [4:0] running_slot, [5] has_task, [6] switched, [7] boosted, [10:8] error_code
    output logic [15:0]                        m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mlfq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mlfq_pkg::*;

    t_cfg r_cfg;
    t_req w_req;
    t_res w_res, r_res;
    logic r_mvalid, w_idle, w_done, w_start;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = w_idle;
    assign w_start       = s_axis_tvalid && w_idle;
    assign w_req.func          = s_axis_tuser;
    assign w_req.slot_id       = s_axis_tdata[4:0];
    assign w_req.runnable_flag = s_axis_tdata[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_count  <= RST_LEVELS;
            r_cfg.quantum_unit <= RST_QUANTUM;
            r_cfg.boost_period <= RST_BOOST;
            r_cfg.tick_step    <= RST_STEP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LEVELS:  r_cfg.level_count  <= i_cfg_data[4:0];
                CFG_QUANTUM: r_cfg.quantum_unit <= i_cfg_data[9:0];
                CFG_BOOST:   r_cfg.boost_period <= i_cfg_data;
                CFG_STEP:    r_cfg.tick_step    <= i_cfg_data[3:0];
                default:     r_cfg.tick_step    <= r_cfg.tick_step;
            endcase
        end
    end

    mlfq_seq #(
        .TASK_SLOTS  (TASK_SLOTS),
        .LEVELS      (LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_start    (w_start),
        .i_req      (w_req),
        .i_res_free (!r_mvalid || m_axis_tready),
        .o_idle     (w_idle),
        .o_done     (w_done),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (w_done) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) r_res <= w_res;
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = {5'b0, r_res.error_code, r_res.boosted, r_res.switched,
                            r_res.has_task, r_res.running_slot};

endmodule

### sim/mlfq_checker.sv
// scoreboard for the mlfq scheduler: follows the event, result and register channels,
// predicts each result from its own copy of the scheduler state and compares it
// depends on mlfq_pkg
module mlfq_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_ev_valid,
    input  logic                              i_ev_ready,
    input  logic [7:0]                        i_ev_data,
    input  logic [mlfq_pkg::FUNC_W-1:0]       i_ev_user,
    input  logic                              i_res_valid,
    input  logic                              i_res_ready,
    input  logic [15:0]                       i_res_data,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mlfq_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import mlfq_pkg::*;

    localparam int NSLOT = DEF_TASK_SLOTS;
    localparam int NLVL  = DEF_LEVELS;
    localparam int DEPTH = DEF_LEVEL_DEPTH;

    t_cfg        cfg;
    bit          present [NSLOT];
    bit          ready_to_run [NSLOT];
    int          lvl_of [NSLOT];
    logic [31:0] used [NSLOT];
    int          members [NLVL][DEPTH];
    int          fill [NLVL];
    int          order [NSLOT];
    int          order_fill;
    int          cur_slot;
    bit          cur_valid;
    logic [31:0] now, slice_start, slice_stop, boost_last;

    t_res sched_results [$];

    assign o_pending = sched_results.size();

    function automatic int levels_on();
        int n;
        n = cfg.level_count;
        if (n < 1) n = 1;
        if (n > NLVL) n = NLVL;
        return n;
    endfunction

    function automatic logic [31:0] slice_len(int lv);
        return 32'(cfg.quantum_unit) * 32'(lv + 1);
    endfunction

    function automatic int find_in_level(int lv, int s);
        for (int i = 0; i < fill[lv]; i++)
            if (members[lv][i] == s) return i;
        return -1;
    endfunction

    function automatic void drop_from_level(int lv, int pos);
        for (int i = pos; i + 1 < fill[lv]; i++) members[lv][i] = members[lv][i+1];
        fill[lv]--;
    endfunction

    function automatic void shift_level(int s, int to);
        int from;
        int pos;
        from = lvl_of[s];
        pos = find_in_level(from, s);
        if (pos < 0) return;
        if (to != from && fill[to] >= DEPTH) return;
        drop_from_level(from, pos);
        members[to][fill[to]] = s;
        fill[to]++;
        lvl_of[s] = to;
        used[s] = 0;
    endfunction

    function automatic int first_ready(int lv, int start);
        for (int i = start; i < fill[lv]; i++)
            if (ready_to_run[members[lv][i]]) return members[lv][i];
        return -1;
    endfunction

    function automatic int find_in_order(int s);
        for (int i = 0; i < order_fill; i++)
            if (order[i] == s) return i;
        return -1;
    endfunction

    // returns 0 when nothing is runnable and the processor goes idle
    function automatic bit pick_task();
        int nl;
        bit had;
        int cur;
        int old_lv;
        int old_idx;
        int pick;
        int start;
        int p;
        logic [31:0] el;
        nl = levels_on();
        had = cur_valid;
        cur = cur_slot;
        old_lv = 0;
        old_idx = -1;
        pick = -1;
        if (had) begin
            el = now - slice_start;
            old_lv = lvl_of[cur];
            old_idx = find_in_level(old_lv, cur);
            used[cur] = (used[cur] > 32'hFFFF_FFFF - el) ? 32'hFFFF_FFFF : used[cur] + el;
            if (used[cur] >= slice_len(old_lv) && old_lv + 1 < nl)
                shift_level(cur, old_lv + 1);
        end
        if (nl == 1) begin
            start = 0;
            if (had) begin
                p = find_in_order(cur);
                if (p >= 0) start = p + 1;
            end
            for (int k = 0; k < order_fill && pick < 0; k++)
                if (ready_to_run[order[(start + k) % order_fill]])
                    pick = order[(start + k) % order_fill];
        end else begin
            for (int lv = 0; lv < NLVL; lv++) begin
                if (first_ready(lv, 0) < 0) continue;
                if (had && lv == old_lv && old_idx >= 0 && old_idx + 1 < fill[lv])
                    pick = first_ready(lv, old_idx + 1);
                if (pick < 0) pick = first_ready(lv, 0);
                break;
            end
        end
        if (pick < 0) begin
            cur_valid = 0;
            cur_slot = 0;
            return 0;
        end
        cur_slot = pick;
        cur_valid = 1;
        slice_start = now;
        slice_stop = now + slice_len(lvl_of[pick]);
        return 1;
    endfunction

    function automatic t_res predict_event(logic [FUNC_W-1:0] fn, int s, bit flag);
        t_res r;
        bit was_valid;
        int was_slot;
        int p;
        int q;
        was_valid = cur_valid;
        was_slot = cur_slot;
        r = '0;
        r.error_code = ERR_OK;
        case (fn)
            FN_TICK: begin
                now = now + 32'(cfg.tick_step);
                if (!cur_valid || now - slice_start >= slice_stop - slice_start)
                    if (!pick_task()) r.error_code = ERR_NO_RUN;
                if (levels_on() > 1 && now - boost_last >= 32'(cfg.boost_period)) begin
                    boost_last = now;
                    for (int i = 0; i < order_fill; i++) shift_level(order[i], 0);
                    r.boosted = 1'b1;
                end
            end
            FN_ADD: begin
                if (present[s]) r.error_code = ERR_PRESENT;
                else if (fill[0] >= DEPTH || order_fill >= NSLOT)
                    r.error_code = ERR_LEVEL_FULL;
                else begin
                    present[s] = 1;
                    ready_to_run[s] = 1;
                    lvl_of[s] = 0;
                    used[s] = 0;
                    order[order_fill++] = s;
                    members[0][fill[0]++] = s;
                end
            end
            FN_SETRUN: begin
                if (!present[s]) r.error_code = ERR_NOT_PRESENT;
                else begin
                    ready_to_run[s] = flag;
                    if (!flag && cur_valid && cur_slot == s)
                        if (!pick_task()) r.error_code = ERR_NO_RUN;
                end
            end
            FN_REMOVE: begin
                if (!present[s]) r.error_code = ERR_NOT_PRESENT;
                else begin
                    p = find_in_level(lvl_of[s], s);
                    q = find_in_order(s);
                    if (p >= 0) drop_from_level(lvl_of[s], p);
                    if (q >= 0) begin
                        for (int i = q; i + 1 < order_fill; i++) order[i] = order[i+1];
                        order_fill--;
                    end
                    present[s] = 0;
                    ready_to_run[s] = 0;
                    if (cur_valid && cur_slot == s) begin
                        cur_valid = 0;
                        cur_slot = 0;
                        if (!pick_task()) r.error_code = ERR_NO_RUN;
                    end
                end
            end
            FN_YIELD: begin
                if (!pick_task()) r.error_code = ERR_NO_RUN;
            end
            default: ;
        endcase
        r.running_slot = cur_valid ? SLOT_W'(cur_slot) : '0;
        r.has_task = cur_valid;
        r.switched = (was_valid != cur_valid) || (cur_valid && was_slot != cur_slot);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        if (!i_rst_n) begin
            cfg = {RST_LEVELS, RST_QUANTUM, RST_BOOST, RST_STEP};
            for (int i = 0; i < NSLOT; i++) begin
                present[i] = 0;
                ready_to_run[i] = 0;
            end
            for (int i = 0; i < NLVL; i++) fill[i] = 0;
            order_fill = 0;
            cur_slot = 0;
            cur_valid = 0;
            now = 0;
            slice_start = 0;
            slice_stop = 0;
            boost_last = 0;
            sched_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LEVELS:  cfg.level_count  = i_cfg_data[4:0];
                    CFG_QUANTUM: cfg.quantum_unit = i_cfg_data[9:0];
                    CFG_BOOST:   cfg.boost_period = i_cfg_data[15:0];
                    CFG_STEP:    cfg.tick_step    = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_ev_valid && i_ev_ready)
                sched_results.push_back(predict_event(i_ev_user, int'(i_ev_data[4:0]),
                                                      i_ev_data[5]));
            if (i_res_valid && i_res_ready) begin
                got.running_slot = i_res_data[4:0];
                got.has_task     = i_res_data[5];
                got.switched     = i_res_data[6];
                got.boosted      = i_res_data[7];
                got.error_code   = i_res_data[10:8];
                if (sched_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result %h with nothing pending", i_res_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = sched_results.pop_front();
                    if (want != got) begin
                        if (o_fail_count < 10) begin
                            $write("mismatch at %0t: slot %0d/%0d run %0d/%0d sw %0d/%0d",
                                   $realtime, want.running_slot, got.running_slot,
                                   want.has_task, got.has_task,
                                   want.switched, got.switched);
                            $display(" boost %0d/%0d err %0d/%0d (exp/act)",
                                     want.boosted, got.boosted,
                                     want.error_code, got.error_code);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### sim/mlfq_task_scheduler_unit_test.sv
// top of the scheduler testbench: clock, reset, directed and random events, register
// phases, random stalls on both channels and the verdict; depends on mlfq_pkg,
// mlfq_checker and mlfq_task_scheduler_unit
module mlfq_task_scheduler_unit_test;
    import mlfq_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  ev_valid;
    logic                  ev_ready;
    logic [7:0]            ev_data;
    logic [FUNC_W-1:0]     ev_func;
    logic                  res_valid;
    logic                  res_ready;
    logic [15:0]           res_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    res_stall;
    bit                    res_took;
    bit                    ev_burst;
    bit                    res_burst;
    int                    slot_pool;

    mlfq_task_scheduler_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .s_axis_tvalid(ev_valid), .s_axis_tready(ev_ready),
        .s_axis_tdata(ev_data), .s_axis_tuser(ev_func),
        .m_axis_tvalid(res_valid), .m_axis_tready(res_ready), .m_axis_tdata(res_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    mlfq_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_ev_valid(ev_valid), .i_ev_ready(ev_ready), .i_ev_data(ev_data),
        .i_ev_user(ev_func),
        .i_res_valid(res_valid), .i_res_ready(res_ready), .i_res_data(res_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // result side stalls
    always @(posedge clk) begin
        res_took <= res_valid && res_ready;
    end

    always @(negedge clk) begin
        int wait_n;
        if (res_took) wait_n = res_burst ? 0 : int'($urandom_range(0, 11));
        else wait_n = res_stall;
        if (wait_n > 0) begin
            res_ready <= 1'b0;
            res_stall <= wait_n - 1;
        end else begin
            res_ready <= 1'b1;
            res_stall <= 0;
        end
        if ($urandom_range(0, 63) == 0) res_burst <= ~res_burst;
    end

    task automatic send_event(logic [FUNC_W-1:0] fn, int s, bit flag);
        int gap;
        @(negedge clk);
        gap = ev_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            ev_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        ev_valid <= 1'b1;
        ev_func <= fn;
        ev_data <= {2'b00, flag, 5'(s)};
        do @(posedge clk); while (!ev_ready);
    endtask

    task automatic end_events();
        @(negedge clk);
        ev_valid <= 1'b0;
    endtask

    task automatic drain();
        end_events();
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_event();
        int r;
        int s;
        logic [FUNC_W-1:0] fn;
        r = $urandom_range(0, 99);
        if (r < 35) fn = FN_TICK;
        else if (r < 55) fn = FN_ADD;
        else if (r < 73) fn = FN_SETRUN;
        else if (r < 85) fn = FN_REMOVE;
        else if (r < 97) fn = FN_YIELD;
        else fn = FUNC_W'($urandom_range(5, 7));
        s = ($urandom_range(0, 99) < 85) ? $urandom_range(0, slot_pool)
                                         : $urandom_range(0, 31);
        send_event(fn, s, $urandom_range(0, 99) < 65);
        if ($urandom_range(0, 31) == 0) ev_burst = ~ev_burst;
    endtask

    initial begin
        logic [4:0]  lv_set [6] = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd31, 5'd2};
        logic [9:0]  q_set  [6] = '{10'd1, 10'd1023, 10'd2, 10'd0, 10'd7, 10'd3};
        logic [15:0] b_set  [6] = '{16'd1, 16'd65535, 16'd20, 16'd0, 16'd50, 16'd300};
        logic [3:0]  t_set  [6] = '{4'd1, 4'd15, 4'd3, 4'd0, 4'd5, 4'd2};
        rst_n = 1'b0;
        ev_valid = 1'b0;
        ev_data = '0;
        ev_func = FN_TICK;
        res_ready = 1'b0;
        res_stall = 0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LEVELS;
        cfg_data = '0;
        ev_burst = 0;
        res_burst = 0;
        slot_pool = 7;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed events at reset settings
        send_event(FN_TICK, 0, 0);
        send_event(FN_YIELD, 0, 0);
        send_event(FN_ADD, 0, 1);
        send_event(FN_ADD, 31, 0);
        send_event(FN_ADD, 0, 1);
        send_event(FN_SETRUN, 5, 1);
        send_event(FN_REMOVE, 7, 0);
        send_event(FN_TICK, 0, 0);
        send_event(FN_YIELD, 0, 0);
        send_event(FN_SETRUN, 31, 0);
        send_event(FN_SETRUN, 31, 1);
        send_event(FN_SETRUN, 0, 0);
        send_event(FUNC_W'(5), 3, 1);
        send_event(FUNC_W'(6), 31, 0);
        send_event(FUNC_W'(7), 0, 1);
        send_event(FN_REMOVE, 0, 0);
        for (int i = 1; i <= 16; i++) send_event(FN_ADD, i, 0);
        send_event(FN_REMOVE, 31, 1);
        send_event(FN_TICK, 0, 0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_LEVELS, CFG_DATA_W'(lv_set[ph]));
            write_reg(CFG_QUANTUM, CFG_DATA_W'(q_set[ph]));
            write_reg(CFG_BOOST, b_set[ph]);
            write_reg(CFG_STEP, CFG_DATA_W'(t_set[ph]));
            slot_pool = (ph == 1) ? 31 : $urandom_range(3, 20);
            for (int n = 0; n < 180; n++) random_event();
            drain();
        end

        if (fail_count == 0) begin
            $display("mlfq_task_scheduler_unit_test: PASS");
        end else begin
            $display("mlfq_task_scheduler_unit_test: FAIL");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("mlfq_task_scheduler_unit_test: FAIL");
        $finish;
    end
endmodule

### files.f
src/mlfq_pkg.sv
src/mlfq_seq.sv
src/mlfq_task_scheduler_unit.sv
sim/mlfq_checker.sv
sim/mlfq_task_scheduler_unit_test.sv
